FILE: design/sacs_pkg.sv
// Shared types, widths and codes for the swap arrangement cost search block.
package sacs_pkg;

	// Field widths of the command and result items
	localparam int CMD_W  = 3;
	localparam int IDX_W  = 6;
	localparam int VAL_W  = 6;
	localparam int COST_W = 32;

	// Configuration port
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;
	localparam int NV_W   = 7;
	localparam logic [NV_W-1:0] NUM_VARS_RST = 7'd64;
	localparam logic REG_NUM_VARS = 1'b0;

	// Default storage depth
	localparam int MAX_VARS_DEF = 64;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_SET_INF = 3'd0,
		CMD_WR_SLOT = 3'd1,
		CMD_COST    = 3'd2,
		CMD_SWAP    = 3'd3,
		CMD_RD_SLOT = 3'd4
	} sacs_cmd_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SI_RA,
		ST_SI_WA,
		ST_SI_RB,
		ST_SI_WB,
		ST_WS,
		ST_RS_RD,
		ST_RS_GET,
		ST_CO_I,
		ST_CO_ROW,
		ST_CO_LAT,
		ST_CO_J,
		ST_CO_END,
		ST_SW_RA,
		ST_SW_RB,
		ST_SW_MA,
		ST_SW_MB,
		ST_SW_LB,
		ST_SW_LOOP,
		ST_SW_CHK,
		ST_SW_WA,
		ST_SW_WB,
		ST_DONE
	} sacs_state_t;

endpackage

FILE: design/sacs_if.sv
// Valid/ready channel interfaces for command items and result items.
interface sacs_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [sacs_pkg::CMD_W-1:0] command;
	logic [sacs_pkg::IDX_W-1:0] index_a;
	logic [sacs_pkg::IDX_W-1:0] index_b;
	logic [sacs_pkg::VAL_W-1:0] item_value;

	modport source (output valid, command, index_a, index_b, item_value, input ready);
	modport sink (input valid, command, index_a, index_b, item_value, output ready);
endinterface

interface sacs_res_if;
	logic                        valid;
	logic                        ready;
	logic [sacs_pkg::VAL_W-1:0]  slot_value;
	logic [sacs_pkg::COST_W-1:0] total_cost;
	logic                        swap_taken;

	modport source (output valid, slot_value, total_cost, swap_taken, input ready);
	modport sink (input valid, slot_value, total_cost, swap_taken, output ready);
endinterface

FILE: design/swap_arrangement_cost_search.sv
// Swap arrangement cost search: influence matrix, ordering store and cost sequencer.
//
// Usage: command items arrive on cmd (valid/ready), one result item per command
// leaves on res. num_vars is written over the APB port at byte address 0 while
// the block is idle. Commands: set influence, write slot, compute cost, try swap,
// read slot. One command is worked on at a time; cmd.ready is high only while
// the sequencer is idle.
// The swap and cost loops are paced by the single read port of the ordering
// store: one position is fetched and accumulated per cycle.
// Reset clears the influence matrix through per-row valid bits (no clearing
// pass), zeroes the stored cost and sets num_vars to 64. The ordering store is
// undefined until written. A result waits in the output register while res is
// stalled; the next command is still taken, and its result is held back in the
// sequencer until the output register frees.
module swap_arrangement_cost_search #(
	parameter int MAX_VARS = sacs_pkg::MAX_VARS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sacs_cmd_if.sink                    cmd,
	sacs_res_if.source                  res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sacs_pkg::APB_AW-1:0] paddr,
	input  logic [sacs_pkg::APB_DW-1:0] pwdata,
	output logic [sacs_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam int NW  = $clog2(MAX_VARS);
	localparam int CW  = $clog2(MAX_VARS + 1);
	localparam int SW  = 2 * CW + 2;
	localparam int DW  = 3 * CW + 2;
	localparam int SQW = 2 * CW;

	sacs_pkg::sacs_state_t state_q, state_d;
	sacs_pkg::sacs_cmd_t   cmd_code;

	logic [sacs_pkg::NV_W-1:0]   num_vars_q;
	logic [sacs_pkg::COST_W-1:0] cost_q;
	logic [CW-1:0]               n_eff;
	logic                        cmd_acc, set_ok, swap_ok, res_load;
	logic                        issue, loop_done;

	// Captured command fields
	logic [sacs_pkg::IDX_W-1:0] a_q, b_q;
	logic [sacs_pkg::VAL_W-1:0] v_q;

	// Ordering store
	logic [sacs_pkg::VAL_W-1:0] ord_mem [MAX_VARS];
	logic [sacs_pkg::VAL_W-1:0] ord_rd_q, o_wdata;
	logic [NW-1:0]              o_raddr, o_waddr;
	logic                       o_we;

	// Influence matrix, one row per variable
	logic [MAX_VARS-1:0] inf_mem [MAX_VARS];
	logic [MAX_VARS-1:0] row_valid_q, row_rd_q, row_eff, m_wdata;
	logic                row_ok_q;
	logic [NW-1:0]       m_raddr, m_waddr;
	logic                m_we;

	// Loop datapath
	logic [CW-1:0]               i_q, idx_q, pidx_s1;
	logic                        pvalid_s1;
	logic [sacs_pkg::VAL_W-1:0]  vi_q, va_q, vb_q;
	logic [MAX_VARS-1:0]         row_a_q, row_b_q;
	logic [SQW-1:0]              sq_q;
	logic [sacs_pkg::COST_W-1:0] acc_q;
	logic signed [SW-1:0]        t_q, step_q;
	logic signed [DW-1:0]        delta_q;
	logic                        hit_a, hit_b, skip;

	// Swap start values: t(0) = b*b - a*a, step = 2(a - b)
	logic signed [7:0]  dab, dba;
	logic signed [8:0]  sba, step0;
	logic signed [16:0] t0;

	// Result register
	logic                        res_valid_q, res_taken_q, taken_q;
	logic [sacs_pkg::VAL_W-1:0]  res_slot_q, slot_q;
	logic [sacs_pkg::COST_W-1:0] res_cost_q;

	assign cmd_acc  = cmd.valid && cmd.ready;
	assign cmd_code = sacs_pkg::sacs_cmd_t'(cmd.command);
	assign cmd.ready = (state_q == sacs_pkg::ST_IDLE);

	assign n_eff = (int'(num_vars_q) > MAX_VARS) ? CW'(MAX_VARS) : CW'(num_vars_q);

	assign set_ok  = (int'(cmd.index_a) < MAX_VARS) && (int'(cmd.index_b) < MAX_VARS);
	assign swap_ok = (cmd.index_a != cmd.index_b)
		&& (int'(cmd.index_a) < int'(n_eff)) && (int'(cmd.index_b) < int'(n_eff));

	assign issue     = (idx_q < n_eff);
	assign loop_done = !issue && !pvalid_s1;
	assign res_load  = (state_q == sacs_pkg::ST_DONE) && (!res_valid_q || res.ready);

	assign row_eff = row_ok_q ? row_rd_q : '0;

	// Bit tests for the position fetched last cycle
	assign hit_a = (int'(ord_rd_q) < MAX_VARS) && row_a_q[NW'(ord_rd_q)];
	assign hit_b = (int'(ord_rd_q) < MAX_VARS) && row_b_q[NW'(ord_rd_q)];
	assign skip  = (int'(pidx_s1) == int'(a_q)) || (int'(pidx_s1) == int'(b_q));

	assign dab   = $signed({2'b0, a_q}) - $signed({2'b0, b_q});
	assign dba   = $signed({2'b0, b_q}) - $signed({2'b0, a_q});
	assign sba   = $signed({3'b0, b_q}) + $signed({3'b0, a_q});
	assign t0    = dba * sba;
	assign step0 = {dab, 1'b0};

	// APB register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == sacs_pkg::REG_NUM_VARS)
		? sacs_pkg::APB_DW'(num_vars_q) : '0;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sacs_pkg::ST_IDLE: begin
				if (cmd_acc) begin
					case (cmd_code)
						sacs_pkg::CMD_SET_INF: state_d = set_ok ? sacs_pkg::ST_SI_RA : sacs_pkg::ST_DONE;
						sacs_pkg::CMD_WR_SLOT: state_d = sacs_pkg::ST_WS;
						sacs_pkg::CMD_COST:    state_d = sacs_pkg::ST_CO_I;
						sacs_pkg::CMD_SWAP:    state_d = swap_ok ? sacs_pkg::ST_SW_RA : sacs_pkg::ST_DONE;
						sacs_pkg::CMD_RD_SLOT: state_d = sacs_pkg::ST_RS_RD;
						default:               state_d = sacs_pkg::ST_DONE;
					endcase
				end
			end
			sacs_pkg::ST_SI_RA:  state_d = sacs_pkg::ST_SI_WA;
			sacs_pkg::ST_SI_WA:  state_d = sacs_pkg::ST_SI_RB;
			sacs_pkg::ST_SI_RB:  state_d = sacs_pkg::ST_SI_WB;
			sacs_pkg::ST_SI_WB:  state_d = sacs_pkg::ST_DONE;
			sacs_pkg::ST_WS:     state_d = sacs_pkg::ST_DONE;
			sacs_pkg::ST_RS_RD:  state_d = sacs_pkg::ST_RS_GET;
			sacs_pkg::ST_RS_GET: state_d = sacs_pkg::ST_DONE;
			sacs_pkg::ST_CO_I: begin
				if (int'(i_q) + 1 >= int'(n_eff)) begin
					state_d = sacs_pkg::ST_CO_END;
				end else begin
					state_d = sacs_pkg::ST_CO_ROW;
				end
			end
			sacs_pkg::ST_CO_ROW: state_d = sacs_pkg::ST_CO_LAT;
			sacs_pkg::ST_CO_LAT: state_d = sacs_pkg::ST_CO_J;
			sacs_pkg::ST_CO_J: begin
				if (loop_done) begin
					state_d = sacs_pkg::ST_CO_I;
				end
			end
			sacs_pkg::ST_CO_END: state_d = sacs_pkg::ST_DONE;
			sacs_pkg::ST_SW_RA:  state_d = sacs_pkg::ST_SW_RB;
			sacs_pkg::ST_SW_RB:  state_d = sacs_pkg::ST_SW_MA;
			sacs_pkg::ST_SW_MA:  state_d = sacs_pkg::ST_SW_MB;
			sacs_pkg::ST_SW_MB:  state_d = sacs_pkg::ST_SW_LB;
			sacs_pkg::ST_SW_LB:  state_d = sacs_pkg::ST_SW_LOOP;
			sacs_pkg::ST_SW_LOOP: begin
				if (loop_done) begin
					state_d = sacs_pkg::ST_SW_CHK;
				end
			end
			sacs_pkg::ST_SW_CHK: state_d = delta_q[DW-1] ? sacs_pkg::ST_SW_WA : sacs_pkg::ST_DONE;
			sacs_pkg::ST_SW_WA:  state_d = sacs_pkg::ST_SW_WB;
			sacs_pkg::ST_SW_WB:  state_d = sacs_pkg::ST_DONE;
			sacs_pkg::ST_DONE: begin
				if (res_load) begin
					state_d = sacs_pkg::ST_IDLE;
				end
			end
			default: state_d = sacs_pkg::ST_IDLE;
		endcase
	end

	// Memory ports driven by the sequencer
	always_comb begin
		o_raddr = '0;
		o_waddr = '0;
		o_wdata = '0;
		o_we    = 1'b0;
		m_raddr = '0;
		m_waddr = '0;
		m_wdata = '0;
		m_we    = 1'b0;
		case (state_q)
			sacs_pkg::ST_SI_RA: m_raddr = NW'(a_q);
			sacs_pkg::ST_SI_WA: begin
				m_we    = 1'b1;
				m_waddr = NW'(a_q);
				m_wdata = row_eff;
				m_wdata[NW'(b_q)] = v_q[0];
			end
			sacs_pkg::ST_SI_RB: m_raddr = NW'(b_q);
			sacs_pkg::ST_SI_WB: begin
				m_we    = 1'b1;
				m_waddr = NW'(b_q);
				m_wdata = row_eff;
				m_wdata[NW'(a_q)] = v_q[0];
			end
			sacs_pkg::ST_WS: begin
				o_we    = (int'(a_q) < MAX_VARS);
				o_waddr = NW'(a_q);
				o_wdata = v_q;
			end
			sacs_pkg::ST_RS_RD:   o_raddr = NW'(a_q);
			sacs_pkg::ST_CO_I:    o_raddr = NW'(i_q);
			sacs_pkg::ST_CO_ROW:  m_raddr = NW'(ord_rd_q);
			sacs_pkg::ST_CO_J:    o_raddr = NW'(idx_q);
			sacs_pkg::ST_SW_RA:   o_raddr = NW'(a_q);
			sacs_pkg::ST_SW_RB:   o_raddr = NW'(b_q);
			sacs_pkg::ST_SW_MA:   m_raddr = NW'(va_q);
			sacs_pkg::ST_SW_MB:   m_raddr = NW'(vb_q);
			sacs_pkg::ST_SW_LOOP: o_raddr = NW'(idx_q);
			sacs_pkg::ST_SW_WA: begin
				o_we    = 1'b1;
				o_waddr = NW'(a_q);
				o_wdata = vb_q;
			end
			sacs_pkg::ST_SW_WB: begin
				o_we    = 1'b1;
				o_waddr = NW'(b_q);
				o_wdata = va_q;
			end
			default: o_we = 1'b0;
		endcase
	end

	// Ordering store
	always_ff @(posedge clk) begin
		if (o_we) begin
			ord_mem[o_waddr] <= o_wdata;
		end
		ord_rd_q <= ord_mem[o_raddr];
	end

	// Influence matrix rows
	always_ff @(posedge clk) begin
		if (m_we) begin
			inf_mem[m_waddr] <= m_wdata;
		end
		row_rd_q <= inf_mem[m_raddr];
		row_ok_q <= row_valid_q[m_raddr];
	end

	// Row valid bits: an unwritten row reads as all zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (m_we) begin
			row_valid_q[m_waddr] <= 1'b1;
		end
	end

	// Control state, configuration and stored cost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sacs_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
			num_vars_q  <= sacs_pkg::NUM_VARS_RST;
			cost_q      <= '0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (psel && penable && pwrite && (paddr[2] == sacs_pkg::REG_NUM_VARS)) begin
				num_vars_q <= pwdata[sacs_pkg::NV_W-1:0];
			end
			if (state_q == sacs_pkg::ST_CO_END) begin
				cost_q <= acc_q;
			end else if (state_q == sacs_pkg::ST_SW_WA) begin
				cost_q <= cost_q + sacs_pkg::COST_W'(delta_q);
			end
		end
	end

	// Datapath: one fetch and one accumulate per loop cycle
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			a_q     <= cmd.index_a;
			b_q     <= cmd.index_b;
			v_q     <= cmd.item_value;
			slot_q  <= '0;
			taken_q <= 1'b0;
			i_q     <= '0;
			acc_q   <= '0;
		end
		case (state_q)
			sacs_pkg::ST_RS_GET: slot_q <= (int'(a_q) < MAX_VARS) ? ord_rd_q : '0;
			sacs_pkg::ST_CO_ROW: vi_q <= ord_rd_q;
			sacs_pkg::ST_CO_LAT: begin
				row_a_q   <= (int'(vi_q) < MAX_VARS) ? row_eff : '0;
				idx_q     <= i_q + 1'b1;
				pvalid_s1 <= 1'b0;
				sq_q      <= SQW'(1);
			end
			sacs_pkg::ST_CO_J: begin
				if (issue) begin
					idx_q   <= idx_q + 1'b1;
					pidx_s1 <= idx_q;
				end
				pvalid_s1 <= issue;
				if (pvalid_s1) begin
					if (hit_a) begin
						acc_q <= acc_q + sacs_pkg::COST_W'(sq_q);
					end
					// next square from (d+1)^2 = d^2 + 2d + 1
					sq_q <= sq_q + SQW'({pidx_s1 - i_q, 1'b1});
				end
				if (loop_done) begin
					i_q <= i_q + 1'b1;
				end
			end
			sacs_pkg::ST_SW_RA: begin
				t_q    <= SW'(t0);
				step_q <= SW'(step0);
			end
			sacs_pkg::ST_SW_RB: va_q <= ord_rd_q;
			sacs_pkg::ST_SW_MA: vb_q <= ord_rd_q;
			sacs_pkg::ST_SW_MB: row_a_q <= (int'(va_q) < MAX_VARS) ? row_eff : '0;
			sacs_pkg::ST_SW_LB: begin
				row_b_q   <= (int'(vb_q) < MAX_VARS) ? row_eff : '0;
				idx_q     <= '0;
				pvalid_s1 <= 1'b0;
				delta_q   <= '0;
			end
			sacs_pkg::ST_SW_LOOP: begin
				if (issue) begin
					idx_q   <= idx_q + 1'b1;
					pidx_s1 <= idx_q;
				end
				pvalid_s1 <= issue;
				if (pvalid_s1) begin
					// t tracks (i-b)^2 - (i-a)^2 for the position under test
					t_q <= t_q + step_q;
					if (!skip && hit_a && !hit_b) begin
						delta_q <= delta_q + DW'(t_q);
					end else if (!skip && hit_b && !hit_a) begin
						delta_q <= delta_q - DW'(t_q);
					end
				end
			end
			sacs_pkg::ST_SW_WA: taken_q <= 1'b1;
			default: ;
		endcase
		if (res_load) begin
			res_slot_q  <= slot_q;
			res_cost_q  <= cost_q;
			res_taken_q <= taken_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.slot_value = res_slot_q;
	assign res.total_cost = res_cost_q;
	assign res.swap_taken = res_taken_q;

`ifndef SYNTHESIS
	// A swap is only written back after a strictly negative change
	a_swap_neg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sacs_pkg::ST_SW_WA |-> delta_q[DW-1] && $past(state_q) == sacs_pkg::ST_SW_CHK)
		else $error("swap applied without a cost drop");

	// A taken swap never carries a slot value
	a_taken_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_taken_q |-> res_slot_q == '0)
		else $error("swap result carries a slot value");

	// An accepted item always makes the block busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command taken while still working");
`endif

endmodule
